### rtl/core/lles_pkg.sv
// Package for the LED light effect sequencer: payload structs, pattern state,
// configuration register indexes and the row geometry constants.
// No dependencies; used by lles_advance and led_light_effect_sequencer.
`timescale 1ns / 1ps

package lles_pkg;

  // Row geometry
  localparam int LEDS_PER_ROW = 5;

  localparam logic [7:0]  ROW_MASK   = 8'((1 << LEDS_PER_ROW) - 1);
  localparam logic [7:0]  TOP_LED    = 8'(1 << (LEDS_PER_ROW - 1));
  localparam logic [31:0] WIN_MASK   = 32'((1 << (2 * LEDS_PER_ROW)) - 1);
  localparam logic [31:0] BACK_START = 32'(1) << (2 * LEDS_PER_ROW);

  // Mode select bits, lowest bit has priority
  localparam logic [3:0] MODE_FILL     = 4'h1;
  localparam logic [3:0] MODE_FORWARD  = 4'h2;
  localparam logic [3:0] MODE_BACKWARD = 4'h4;
  localparam logic [3:0] MODE_SCANNER  = 4'h8;

  // Speed button bits
  localparam int SPEED_SLOWER = 0;
  localparam int SPEED_FASTER = 1;
  localparam int SPEED_RESET  = 2;

  // Configuration register indexes
  localparam logic CFG_DEFAULT_PERIOD = 1'b0;
  localparam logic CFG_LONGEST_PERIOD = 1'b1;

  // Reset values of the configuration registers
  localparam logic [7:0] DEFAULT_PERIOD_RST = 8'd20;
  localparam logic [7:0] LONGEST_PERIOD_RST = 8'd200;

  typedef struct packed {
    logic [7:0] speed_buttons;
    logic [7:0] mode_buttons_a;
    logic [7:0] mode_buttons_b;
  } lles_in_t;

  typedef struct packed {
    logic [7:0] row_one;
    logic [7:0] row_two;
  } lles_out_t;

  // Pattern state touched by one step
  typedef struct packed {
    logic [31:0] pattern;
    logic        direction_up;
    logic [7:0]  row_one;
    logic [7:0]  row_two;
  } lles_pat_t;

endpackage

### rtl/core/lles_advance.sv
// One pattern step of the LED sequencer for the selected mode.
// Pure combinational; depends on lles_pkg.
`timescale 1ns / 1ps

module lles_advance (
  input  logic [3:0]         mode_bits,
  input  lles_pkg::lles_pat_t cur,
  output lles_pkg::lles_pat_t nxt
);
  import lles_pkg::*;

  logic [31:0] shl;
  logic [31:0] shl_fill;
  logic [31:0] shr;
  logic [7:0]  row_up;
  logic [7:0]  row_dn;
  logic [31:0] new_pat;

  assign shl      = cur.pattern << 1;
  assign shl_fill = (cur.pattern << 1) + 32'd1;
  assign shr      = cur.pattern >> 1;
  assign row_up   = cur.row_one << 1;
  assign row_dn   = cur.row_one >> 1;

  always_comb begin
    nxt     = cur;
    new_pat = cur.pattern;
    if ((mode_bits & MODE_FILL) != 4'h0) begin
      // Fill up to the full window, then empty it again
      if (cur.direction_up) begin
        if ((cur.pattern & WIN_MASK) == 32'd0) begin
          new_pat = 32'd1;
        end else begin
          new_pat = shl_fill;
          if (shl_fill >= WIN_MASK) nxt.direction_up = 1'b0;
        end
      end else begin
        new_pat = shl;
        if ((shl & WIN_MASK) == 32'd0) nxt.direction_up = 1'b1;
      end
    end else if ((mode_bits & MODE_FORWARD) != 4'h0) begin
      new_pat = (shl > WIN_MASK || shl == 32'd0) ? 32'd1 : shl;
    end else if ((mode_bits & MODE_BACKWARD) != 4'h0) begin
      // Restart lands just above the window: one dark step
      new_pat = (shr > WIN_MASK || shr == 32'd0) ? BACK_START : shr;
    end

    if ((mode_bits & (MODE_FILL | MODE_FORWARD | MODE_BACKWARD)) != 4'h0) begin
      nxt.pattern = new_pat;
      nxt.row_one = new_pat[7:0] & ROW_MASK;
      nxt.row_two = new_pat[LEDS_PER_ROW +: 8] & ROW_MASK;
    end else if ((mode_bits & MODE_SCANNER) != 4'h0) begin
      // Scanner bounces between LED one and the top LED, both rows alike
      if (cur.row_one == 8'd0) begin
        nxt.row_one = 8'd1;
      end else if (cur.direction_up) begin
        nxt.row_one = row_up;
        if (row_up >= TOP_LED) nxt.direction_up = 1'b0;
      end else begin
        nxt.row_one = row_dn;
        if (row_dn <= 8'd1) nxt.direction_up = 1'b1;
      end
      nxt.row_two = nxt.row_one;
    end
  end

endmodule

### rtl/core/led_light_effect_sequencer.sv
// Top level of the LED light effect sequencer: input register, tick countdown,
// speed control, pattern state and result register. Depends on lles_pkg and
// lles_advance.
`timescale 1ns / 1ps

// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+-----------------------------------
// in_      | input     | in_valid / in_stall | lles_in_t: speed + two mode bytes
// out_     | output    | out_valid/out_stall | lles_out_t: row_one, row_two
// cfg_     | input     | cfg_write_en        | cfg_index (1 bit), cfg_data (8 bit)
//
// One transaction per clock sustained while out_stall is low; each one passes
// the input register, then the step logic into the result register.
// rst_n is synchronous, active low; period returns to 20 and mode to fill-up.
// A stalled result holds the pipe: in_stall rises once the input register is
// also full, so no transaction is dropped or repeated.

module led_light_effect_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lles_pkg::lles_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lles_pkg::lles_out_t out_data,
  input  logic                cfg_write_en,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data
);
  import lles_pkg::*;

  // Configuration
  logic [7:0] default_period_r;
  logic [7:0] longest_period_r;

  // Pipe control and payload
  logic       in_vld_r;
  lles_in_t   in_r;
  logic       out_vld_r;
  lles_out_t  out_r;
  logic       out_free;
  logic       fire;

  // Sequencer state
  lles_pat_t       pat_r;
  lles_pat_t       pat_step;
  lles_pat_t       pat_nxt;
  logic [3:0]      mode_r;
  logic [3:0]      mode_nxt;
  logic [3:0]      sel;
  logic signed [8:0] countdown_r;
  logic signed [8:0] countdown_nxt;
  logic signed [8:0] cd_dec;
  logic            step_hit;
  logic [7:0]      period_r;
  logic [7:0]      period_nxt;
  logic [7:0]      last_speed_r;
  logic [7:0]      last_speed_nxt;

  assign out_free  = !out_vld_r || !out_stall;
  assign fire      = in_vld_r && out_free;
  assign in_stall  = in_vld_r && !out_free;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_period_r <= DEFAULT_PERIOD_RST;
      longest_period_r <= LONGEST_PERIOD_RST;
    end else if (cfg_write_en) begin
      if (cfg_index == CFG_DEFAULT_PERIOD) default_period_r <= cfg_data;
      if (cfg_index == CFG_LONGEST_PERIOD) longest_period_r <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) in_r <= in_data;
  end

  // Mode select and tick countdown
  assign sel      = in_r.mode_buttons_a[3:0] | in_r.mode_buttons_b[3:0];
  assign mode_nxt = (sel != 4'h0) ? sel : mode_r;
  assign cd_dec   = countdown_r - 9'sd1;
  assign step_hit = cd_dec[8] || (cd_dec == 9'sd0);

  lles_advance u_advance (
    .mode_bits (mode_nxt),
    .cur       (pat_r),
    .nxt       (pat_step)
  );

  assign pat_nxt       = step_hit ? pat_step : pat_r;
  assign countdown_nxt = step_hit ? $signed({1'b0, period_r}) : cd_dec;

  // Speed buttons, one action per press
  always_comb begin
    period_nxt     = period_r;
    last_speed_nxt = last_speed_r;
    if (last_speed_r == 8'd0) begin
      if (in_r.speed_buttons[SPEED_SLOWER]) begin
        if (period_r < longest_period_r) period_nxt = period_r + 8'd1;
        last_speed_nxt = in_r.speed_buttons;
      end else if (in_r.speed_buttons[SPEED_FASTER]) begin
        if (period_r > 8'd1) period_nxt = period_r - 8'd1;
        last_speed_nxt = in_r.speed_buttons;
      end else if (in_r.speed_buttons[SPEED_RESET]) begin
        period_nxt     = default_period_r;
        last_speed_nxt = in_r.speed_buttons;
      end
    end else if (in_r.speed_buttons == 8'd0) begin
      last_speed_nxt = 8'd0;
    end
  end

  // State update, taken with each transaction into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r        <= '0;
      mode_r       <= MODE_FILL;
      countdown_r  <= 9'sd0;
      period_r     <= DEFAULT_PERIOD_RST;
      last_speed_r <= 8'd0;
    end else if (fire) begin
      pat_r        <= pat_nxt;
      mode_r       <= mode_nxt;
      countdown_r  <= countdown_nxt;
      period_r     <= period_nxt;
      last_speed_r <= last_speed_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r.row_one <= pat_nxt.row_one;
      out_r.row_two <= pat_nxt.row_two;
    end
  end

endmodule
